FILE: rtl/clns_pkg.sv
// Shared types, constants and the init table for the character LCD nibble sequencer.
// No dependencies; imported by every module in rtl/.
package clns_pkg;

  // Sequencer phase
  typedef enum logic [1:0] {
    PH_POWER = 2'd0,
    PH_INIT  = 2'd1,
    PH_READY = 2'd2,
    PH_ESC   = 2'd3
  } phase_t;

  // One bus job: a byte sent as one or two nibbles
  typedef struct packed {
    logic [7:0] word;
    logic       rs;     // register select, 1 = character data
    logic       two;    // send low nibble after the high one
  } job_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic empty;
    job_t head;
  } q_stat_t;

  localparam int          QUEUE_DEPTH     = 2;
  localparam int          INIT_WORDS      = 9;
  localparam logic [7:0]  ESC_RESET       = 8'd27;
  localparam logic [7:0]  BYTE_CLEAR      = 8'hFF;
  localparam logic [7:0]  BYTE_HOME       = 8'h40;  // '@'
  localparam logic [7:0]  CMD_CLEAR       = 8'h01;
  localparam logic [7:0]  CMD_HOME        = 8'h02;
  localparam logic [1:0]  FUNC_SET_4BIT   = 2'b10;  // bits 5:4 of a function-set word
  localparam logic        KIND_TICK       = 1'b0;

  // Power-up init words
  function automatic logic [7:0] init_word(input logic [3:0] idx);
    logic [7:0] w;
    case (idx)
      4'd0:    w = 8'h30;
      4'd1:    w = 8'h30;
      4'd2:    w = 8'h30;
      4'd3:    w = 8'h20;
      4'd4:    w = 8'h28;
      4'd5:    w = 8'h0C;
      4'd6:    w = 8'h06;
      4'd7:    w = 8'h01;
      4'd8:    w = 8'h02;
      default: w = 8'h00;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer: front end, job queue, back end.
// Depends on clns_pkg, clns_front, clns_queue, clns_back.
//
// Usage:
//  - Input channel (in_valid/in_stall): each item is a tick (in_kind = 0) or a byte
//    (in_kind = 1, in_byte_value). The first tick leaves power-up, the next nine
//    ticks each send one init word, the tick after that makes the block ready.
//    Bytes before ready are dropped.
//  - Output channel (out_valid/out_stall): one item per enable pulse on the LCD
//    bus: out_nibble, out_data_select (0 control, 1 data), out_last on the final
//    nibble of an input item. Items that cause nothing produce no output.
//  - Config channel (cfg_valid/cfg_ready): writes the escape code; always ready.
//    Write it only while the block is idle.
//  - Path: the first nibble of an item passes through the job queue, then is loaded
//    into the output register, from which it is valid.
//  - Throughput: the back end sends one nibble per cycle while out_stall is low;
//    the front end takes one item per cycle while the job queue (QDEPTH entries)
//    has room, and raises in_stall when it is full.
//  - Reset (rst_n low, synchronous): power-up phase, 8-bit mode, escape code 27,
//    queue and output register empty.
//  - A stalled output holds its nibble; jobs back up in the queue, then in_stall.
module char_lcd_nibble_sequencer #(
  parameter int QDEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_nibble,
  output logic        out_data_select,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_escape_code
);
  import clns_pkg::*;

  logic      in_accept;
  logic      push;
  logic      pop;
  logic      full;
  job_t      job;
  q_stat_t   stat;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign in_accept = in_valid && !in_stall;

  clns_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .kind       (in_kind),
    .byte_value (in_byte_value),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_escape_code),
    .push       (push),
    .job        (job)
  );

  clns_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .full     (full),
    .stat     (stat)
  );

  clns_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .stat            (stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_nibble      (out_nibble),
    .out_data_select (out_data_select),
    .out_last        (out_last)
  );

endmodule

FILE: rtl/clns_front.sv
// Front end: takes tick/byte items, tracks init phase and bus mode, emits bus jobs.
// Depends on clns_pkg.
module clns_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              kind,
  input  logic [7:0]        byte_value,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  output logic              push,
  output clns_pkg::job_t    job
);
  import clns_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        fb_r, fb_nxt;
  logic [7:0]  esc_r;
  logic        send_ctrl, send_data;
  logic [7:0]  word;

  // State and escape register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_POWER;
      idx_r   <= '0;
      fb_r    <= 1'b0;
      esc_r   <= ESC_RESET;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      fb_r    <= fb_nxt;
      if (cfg_we) begin
        esc_r <= cfg_data;
      end
    end
  end

  // Classify the item and pick the word to send
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    send_ctrl = 1'b0;
    send_data = 1'b0;
    word      = byte_value;
    if (accept) begin
      if (kind == KIND_TICK) begin
        unique case (phase_r)
          PH_POWER: begin
            idx_nxt   = '0;
            phase_nxt = PH_INIT;
          end
          PH_INIT: begin
            if (idx_r < 4'(INIT_WORDS)) begin
              word      = init_word(idx_r);
              idx_nxt   = idx_r + 4'd1;
              send_ctrl = 1'b1;
            end else begin
              phase_nxt = PH_READY;
            end
          end
          PH_READY, PH_ESC: ;
        endcase
      end else begin
        unique case (phase_r)
          PH_READY: begin
            priority if (byte_value == BYTE_CLEAR) begin
              word      = CMD_CLEAR;
              send_ctrl = 1'b1;
            end else if (byte_value == esc_r) begin
              phase_nxt = PH_ESC;
            end else begin
              send_data = 1'b1;
            end
          end
          PH_ESC: begin
            priority if (byte_value[7]) begin
              send_ctrl = 1'b1;
            end else if (byte_value == BYTE_HOME) begin
              word      = CMD_HOME;
              send_ctrl = 1'b1;
            end else begin
              // any other armed byte is dropped
            end
            phase_nxt = PH_READY;
          end
          PH_POWER, PH_INIT: ;
        endcase
      end
    end
    // Function-set word in 8-bit mode switches the bus to 4 bits
    fb_nxt = fb_r;
    if (send_ctrl && !fb_r && word[5:4] == FUNC_SET_4BIT) begin
      fb_nxt = 1'b1;
    end
    push     = send_ctrl | send_data;
    job.word = word;
    job.rs   = send_data;
    job.two  = send_data | fb_r;
  end

  a_ready_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READY || phase_r == PH_ESC) |-> idx_r == 4'(INIT_WORDS))
    else $error("ready phase with init index not at table end");
  a_fb_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fb_r |=> fb_r)
    else $error("4-bit mode dropped");
  a_push_phase: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (accept && phase_r != PH_POWER))
    else $error("job pushed without an item or at power up");

endmodule

FILE: rtl/clns_queue.sv
// Short job queue between front and back ends.
// Depends on clns_pkg.
module clns_queue #(
  parameter int DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  clns_pkg::job_t    push_job,
  input  logic              pop,
  output logic              full,
  output clns_pkg::q_stat_t stat
);
  import clns_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t           mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign full       = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.head  = mem[rd_ptr_r];

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

endmodule

FILE: rtl/clns_back.sv
// Back end: splits queued jobs into nibbles and holds them in the output register.
// Depends on clns_pkg.
module clns_back (
  input  logic              clk,
  input  logic              rst_n,
  input  clns_pkg::q_stat_t stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_nibble,
  output logic              out_data_select,
  output logic              out_last
);
  import clns_pkg::*;

  logic        second_r;
  logic        out_valid_r;
  logic [3:0]  nibble_r;
  logic        rs_r;
  logic        last_r;
  logic        load;

  // Load a new nibble when the output register is free or being drained
  assign load = !stat.empty && (!out_valid_r || !out_stall);
  assign pop  = load && (second_r || !stat.head.two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        second_r <= !second_r && stat.head.two;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      nibble_r <= second_r ? stat.head.word[3:0] : stat.head.word[7:4];
      rs_r     <= stat.head.rs;
      last_r   <= second_r || !stat.head.two;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_nibble      = nibble_r;
  assign out_data_select = rs_r;
  assign out_last        = last_r;

  a_second_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> !stat.empty)
    else $error("low nibble pending with empty queue");
  a_second_two: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> stat.head.two)
    else $error("low nibble pending for a one-nibble job");
  a_high_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(second_r) |-> (out_valid_r && !last_r))
    else $error("high nibble of a two-nibble job flagged last");

endmodule
